@@ rtl/core/wsfd_pkg.sv @@
// Shared types and constants of the WebSocket frame decoder.
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_BYTE  = 3'd0,
    ST_EMPTY = 3'd1,
    ST_BADOP = 3'd2,
    ST_TRUNC = 3'd3,
    ST_END   = 3'd4
  } status_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
    status_t    status;
  } result_t;

endpackage

@@ rtl/core/websocket_frame_decoder.sv @@
// Top level of the WebSocket receive frame decoder.
//
//   channel  direction  tdata          tuser                   tlast
//   in_      slave      stream byte    end-of-stream flag      -
//   out_     master     payload byte   kind, status            last of frame
//
// A request is registered on acceptance and handled once the output register is free;
// its result, if any, is loaded into the output register when it is handled.
// One request per cycle is taken while the output register is free or drained.
// Only a stall on the output limits throughput.
// Reset clears the valid flags and the parser state and leaves the decoder expecting a first header byte.
// A stall on the output holds both stages; no request or result is dropped.
module websocket_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [3:0] out_tuser,  // [0] frame_kind, [3:1] status
  output logic       out_tlast
);
  import wsfd_pkg::*;

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    out_free;
  logic    step_en;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.mode = in_tuser[0];
  assign in_item.data = in_tdata;
  assign step_en      = hold_valid && out_free;

  wsfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .advance    (step_en)
  );

  wsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (hold_item),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && res_valid),
    .load_res  (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = {out_res.status, out_res.kind};
  assign out_tlast = out_res.last;

endmodule

@@ rtl/core/wsfd_in_reg.sv @@
// Input register stage holding one accepted stream request.
module wsfd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  wsfd_pkg::item_t in_item,
  output logic           hold_valid,
  output wsfd_pkg::item_t hold_item,
  input  logic           advance
);
  import wsfd_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/core/wsfd_parser.sv @@
// Frame header parser, payload unmasking and decoder state.
module wsfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  wsfd_pkg::item_t   item,
  output logic              res_valid,
  output wsfd_pkg::result_t res
);
  import wsfd_pkg::*;

  phase_t       phase_r, phase_nxt;
  logic [3:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]   opcode_r, opcode_nxt;
  logic         mask_r, mask_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [31:0]  key_r, key_nxt;
  logic [1:0]   pos_r, pos_nxt;

  logic [6:0]   len7;
  logic         is_ext;
  logic [63:0]  ext_len;
  logic [31:0]  key_shift;
  logic [3:0]   cnt_dec;
  logic [63:0]  rem_dec;
  logic         pay_last;
  logic         op_ok;
  logic         kind;
  logic         hd_event;
  logic [63:0]  hd_len;
  logic [7:0]   key_byte;
  logic [7:0]   pay_byte;

  assign len7      = item.data[6:0];
  assign is_ext    = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
  assign ext_len   = {rem_r[55:0], item.data};
  assign key_shift = {key_r[23:0], item.data};
  assign cnt_dec   = hdr_cnt_r - 4'd1;
  assign rem_dec   = rem_r - 64'd1;
  assign pay_last  = (rem_dec == 64'd0);
  assign op_ok     = (opcode_r == OP_TEXT) || (opcode_r == OP_BINARY);
  assign kind      = (opcode_r == OP_BINARY);

  always_comb begin
    unique case (pos_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      2'd3: key_byte = key_r[7:0];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign pay_byte = mask_r ? (item.data ^ key_byte) : item.data;

  // The header ends on the second byte, the last length byte or the last key byte.
  always_comb begin
    hd_event = 1'b0;
    hd_len   = rem_r;
    if (!item.mode) begin
      unique case (phase_r)
        PH_HDR1: begin
          hd_event = !is_ext && !item.data[7];
          hd_len   = {57'd0, len7};
        end
        PH_EXTLEN: begin
          hd_event = (cnt_dec == 4'd0) && !mask_r;
          hd_len   = ext_len;
        end
        PH_MASK: begin
          hd_event = (cnt_dec == 4'd0);
          hd_len   = rem_r;
        end
        default: begin
          hd_event = 1'b0;
          hd_len   = rem_r;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    opcode_nxt  = opcode_r;
    mask_nxt    = mask_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    if (phase_r == PH_ERROR) begin
      phase_nxt = PH_ERROR;
    end else if (item.mode) begin
      if (phase_r != PH_HDR0) begin
        phase_nxt = PH_ERROR;
      end
    end else begin
      unique case (phase_r)
        PH_HDR0: begin
          opcode_nxt = item.data[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt = item.data[7];
          key_nxt  = 32'd0;
          if (is_ext) begin
            rem_nxt     = 64'd0;
            hdr_cnt_nxt = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_nxt   = PH_EXTLEN;
          end else begin
            rem_nxt = {57'd0, len7};
            if (item.data[7]) begin
              hdr_cnt_nxt = KEY_BYTES;
              phase_nxt   = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          rem_nxt     = ext_len;
          hdr_cnt_nxt = cnt_dec;
          if ((cnt_dec == 4'd0) && mask_r) begin
            hdr_cnt_nxt = KEY_BYTES;
            phase_nxt   = PH_MASK;
          end
        end
        PH_MASK: begin
          key_nxt     = key_shift;
          hdr_cnt_nxt = cnt_dec;
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_r + 2'd1;
          rem_nxt = rem_dec;
          if (pay_last) begin
            phase_nxt = op_ok ? PH_HDR0 : PH_ERROR;
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
      if (hd_event) begin
        pos_nxt = 2'd0;
        if (hd_len != 64'd0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = op_ok ? PH_HDR0 : PH_ERROR;
        end
      end
    end
  end

  // Result of the current request.
  always_comb begin
    res_valid  = 1'b0;
    res.data   = 8'd0;
    res.kind   = 1'b0;
    res.last   = 1'b0;
    res.status = ST_BYTE;
    priority if (phase_r == PH_ERROR) begin
      res_valid = 1'b0;
    end else if (item.mode) begin
      res_valid  = 1'b1;
      res.status = (phase_r == PH_HDR0) ? ST_END : ST_TRUNC;
    end else if (hd_event && (hd_len == 64'd0)) begin
      res_valid  = 1'b1;
      res.kind   = op_ok ? kind : 1'b0;
      res.last   = op_ok;
      res.status = op_ok ? ST_EMPTY : ST_BADOP;
    end else if (phase_r == PH_PAYLOAD) begin
      if (op_ok) begin
        res_valid = 1'b1;
        res.data  = pay_byte;
        res.kind  = kind;
        res.last  = pay_last;
      end else if (pay_last) begin
        res_valid  = 1'b1;
        res.status = ST_BADOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      hdr_cnt_r <= 4'd0;
      opcode_r  <= 4'd0;
      mask_r    <= 1'b0;
      rem_r     <= 64'd0;
      key_r     <= 32'd0;
      pos_r     <= 2'd0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      opcode_r  <= opcode_nxt;
      mask_r    <= mask_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      pos_r     <= pos_nxt;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERROR) |=> (phase_r == PH_ERROR))
    else $error("decoder left the error state without reset");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_EXTLEN) || (phase_r == PH_MASK)) |-> (hdr_cnt_r != 4'd0))
    else $error("header byte count is zero inside the extended header");

  a_payload_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (rem_r != 64'd0))
    else $error("payload phase with no bytes left");

  a_key_step: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (phase_r == PH_PAYLOAD) && !item.mode)
      |=> (pos_r == $past(pos_r) + 2'd1))
    else $error("mask key position did not advance on a payload byte");

endmodule

@@ rtl/core/wsfd_out_reg.sv @@
// Output register holding one result until the downstream side takes it.
module wsfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wsfd_pkg::result_t load_res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output wsfd_pkg::result_t out_res
);
  import wsfd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule
